// File: rtl/pwz_pkg.sv
// ----------------------------------------------------------------------------
// pwz_pkg: shared definitions for the pilot-wire zone controller
// mode, action, status and drive codes, register defaults, shared types
// ----------------------------------------------------------------------------
package pwz_pkg;

	localparam int ZONES_DEF = 7;

	localparam int ACTION_W = 3;
	localparam int ZONE_W = 4;
	localparam int MODE_W = 3;
	localparam int STATUS_W = 2;
	localparam int DRIVE_W = 14;
	localparam int LEVEL_W = 3;
	localparam int PTR_W = 3;
	localparam int CFG_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int STATE_W = 3;

	// actions
	localparam logic [ACTION_W-1:0] ACT_SET = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SHED = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_RESTORE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_ROTATE = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_TICK = 3'd5;

	// zone modes
	localparam logic [MODE_W-1:0] MODE_COMFORT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ECO = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FROST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_OFF = 3'd3;
	localparam logic [MODE_W-1:0] MODE_C1 = 3'd4;
	localparam logic [MODE_W-1:0] MODE_C2 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SHED = 3'd6;

	// pilot wire patterns
	localparam logic [1:0] DRV_COMFORT = 2'd0;
	localparam logic [1:0] DRV_OFF = 2'd1;
	localparam logic [1:0] DRV_FROST = 2'd2;
	localparam logic [1:0] DRV_ECO = 2'd3;

	// result status
	localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_STORED = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_C1_ON = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C1_OFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C2_ON = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C2_OFF = 2'd3;

	localparam logic [CFG_W-1:0] C1_ON_RST = 9'd3;
	localparam logic [CFG_W-1:0] C1_OFF_RST = 9'd297;
	localparam logic [CFG_W-1:0] C2_ON_RST = 9'd7;
	localparam logic [CFG_W-1:0] C2_OFF_RST = 9'd293;

	typedef struct packed {
		logic [CFG_W-1:0] c1_on;
		logic [CFG_W-1:0] c1_off;
		logic [CFG_W-1:0] c2_on;
		logic [CFG_W-1:0] c2_off;
	} cfg_t;

	typedef struct packed {
		logic [CFG_W-1:0] count;
		logic low;
	} phase_t;

	function automatic logic [1:0] drive_code(input logic [MODE_W-1:0] m, input logic low);
		logic [1:0] d;
		case (m)
			MODE_COMFORT: d = DRV_COMFORT;
			MODE_ECO: d = DRV_ECO;
			MODE_OFF: d = DRV_OFF;
			MODE_C1, MODE_C2: d = low ? DRV_COMFORT : DRV_ECO;
			default: d = DRV_FROST;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/pilot_wire_zone_controller_with_shedding_core.sv
// ----------------------------------------------------------------------------
// pilot_wire_zone_controller_with_shedding_core
// pilot-wire heating zone controller with ring load shedding
// ----------------------------------------------------------------------------
// Requests come in on in_valid/in_stall (action, zone, mode); every request
// gives exactly one result on out_valid/out_stall (status, zone_mode, drive,
// shed_level, oldest_shed_zone). The on/off phase lengths are written by the
// user through cfg_wr_en/cfg_index/cfg_data only while the block is idle;
// the block itself does not enforce this. A small sequencer handles one
// request at a time; in_stall is high from the cycle after a request is
// taken until its result is loaded. From EXEC, set, query and bad requests
// go to FINISH; a restore passes REST, a shed SHPREP and SHED, a rotate
// REST, SHPREP and SHED, and a tick sweeps the zones one per cycle in TICK
// through the single phase compare/increment unit, all before FINISH. The
// next request can be taken in the cycle the result appears.
// A result waits in the output register while out_stall is high; the
// sequencer holds its finished result until that register frees up.
// Reset puts every zone in frost protection, clears shedding (oldest pointer
// to zone 1) and loads the default phase lengths.
// ----------------------------------------------------------------------------
module pilot_wire_zone_controller_with_shedding_core #(
	parameter int ZONES = pwz_pkg::ZONES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pwz_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwz_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pwz_pkg::ACTION_W-1:0]    action,
	input  logic [pwz_pkg::ZONE_W-1:0]      zone,
	input  logic [pwz_pkg::MODE_W-1:0]      mode,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pwz_pkg::STATUS_W-1:0]    status,
	output logic [pwz_pkg::MODE_W-1:0]      zone_mode,
	output logic [pwz_pkg::DRIVE_W-1:0]     drive,
	output logic [pwz_pkg::LEVEL_W-1:0]     shed_level,
	output logic [pwz_pkg::PTR_W-1:0]       oldest_shed_zone
);

	localparam int IW = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int CW = $clog2(ZONES + 1);
	localparam int PAD_W = (2 * ZONES > pwz_pkg::DRIVE_W) ? 2 * ZONES : pwz_pkg::DRIVE_W;

	localparam logic [pwz_pkg::STATE_W-1:0] S_IDLE = 3'd0;
	localparam logic [pwz_pkg::STATE_W-1:0] S_EXEC = 3'd1;
	localparam logic [pwz_pkg::STATE_W-1:0] S_REST = 3'd2;
	localparam logic [pwz_pkg::STATE_W-1:0] S_SHPREP = 3'd3;
	localparam logic [pwz_pkg::STATE_W-1:0] S_SHED = 3'd4;
	localparam logic [pwz_pkg::STATE_W-1:0] S_TICK = 3'd5;
	localparam logic [pwz_pkg::STATE_W-1:0] S_FINISH = 3'd6;

	logic [pwz_pkg::STATE_W-1:0]  state_q;
	logic [pwz_pkg::ACTION_W-1:0] act_q;
	logic [pwz_pkg::MODE_W-1:0]   mode_q;
	logic                         zone_ok_q;
	logic [IW-1:0]                idx_q;
	logic [pwz_pkg::STATUS_W-1:0] res_status_q;
	logic [pwz_pkg::MODE_W-1:0]   res_zmode_q;

	logic [pwz_pkg::MODE_W-1:0]   zone_state_q [ZONES];
	logic [pwz_pkg::MODE_W-1:0]   saved_mode_q [ZONES];
	pwz_pkg::phase_t              phase_q [ZONES];
	logic [CW-1:0]                shed_cnt_q;
	logic [CW-1:0]                oldest_q;
	pwz_pkg::cfg_t                cfg_q;

	logic                         out_valid_q;
	logic [pwz_pkg::STATUS_W-1:0] status_q;
	logic [pwz_pkg::MODE_W-1:0]   zone_mode_q;
	logic [pwz_pkg::DRIVE_W-1:0]  drive_q;
	logic [pwz_pkg::LEVEL_W-1:0]  shed_level_q;
	logic [pwz_pkg::PTR_W-1:0]    oldest_out_q;

	logic                         in_take;
	logic                         out_free;
	logic                         zone_ok;
	logic [CW:0]                  tgt_sum;
	logic [CW:0]                  tgt_wrap;
	logic [IW-1:0]                shed_idx;
	logic [IW-1:0]                rest_idx;
	logic [CW-1:0]                oldest_next;
	logic [pwz_pkg::MODE_W-1:0]   cur_mode;
	logic [pwz_pkg::MODE_W-1:0]   cur_saved;
	pwz_pkg::phase_t              phase_nxt;
	logic [2*ZONES-1:0]           drv_codes;
	logic [PAD_W-1:0]             drv_pad;

	assign in_stall = (state_q != S_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign zone_ok = (zone >= pwz_pkg::ZONE_W'(1)) && (zone <= pwz_pkg::ZONE_W'(ZONES));

	// ring position of the next zone to shed, sum stays below twice ZONES
	assign tgt_sum = (CW+1)'(oldest_q) - (CW+1)'(1) + (CW+1)'(shed_cnt_q);
	assign tgt_wrap = (tgt_sum >= (CW+1)'(ZONES)) ? tgt_sum - (CW+1)'(ZONES) : tgt_sum;
	assign shed_idx = IW'(tgt_wrap);
	assign rest_idx = IW'(oldest_q - CW'(1));
	assign oldest_next = (oldest_q == CW'(ZONES)) ? CW'(1) : oldest_q + CW'(1);

	assign cur_mode = zone_state_q[idx_q];
	assign cur_saved = saved_mode_q[idx_q];

	pwz_phase_unit u_phase (
		.mode (cur_mode),
		.cur  (phase_q[idx_q]),
		.cfg  (cfg_q),
		.nxt  (phase_nxt)
	);

	always_comb begin
		for (int z = 0; z < ZONES; z++) begin
			drv_codes[2*z +: 2] = pwz_pkg::drive_code(zone_state_q[z], phase_q[z].low);
		end
		drv_pad = PAD_W'(drv_codes);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c1_on <= pwz_pkg::C1_ON_RST;
			cfg_q.c1_off <= pwz_pkg::C1_OFF_RST;
			cfg_q.c2_on <= pwz_pkg::C2_ON_RST;
			cfg_q.c2_off <= pwz_pkg::C2_OFF_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pwz_pkg::REG_C1_ON: cfg_q.c1_on <= cfg_data;
				pwz_pkg::REG_C1_OFF: cfg_q.c1_off <= cfg_data;
				pwz_pkg::REG_C2_ON: cfg_q.c2_on <= cfg_data;
				pwz_pkg::REG_C2_OFF: cfg_q.c2_off <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and zone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= pwz_pkg::ACT_SET;
			mode_q <= pwz_pkg::MODE_COMFORT;
			zone_ok_q <= 1'b0;
			idx_q <= '0;
			res_status_q <= pwz_pkg::STAT_OK;
			res_zmode_q <= pwz_pkg::MODE_COMFORT;
			shed_cnt_q <= '0;
			oldest_q <= CW'(1);
			for (int z = 0; z < ZONES; z++) begin
				zone_state_q[z] <= pwz_pkg::MODE_FROST;
				saved_mode_q[z] <= pwz_pkg::MODE_FROST;
				phase_q[z] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						act_q <= action;
						mode_q <= mode;
						zone_ok_q <= zone_ok;
						idx_q <= IW'(zone - pwz_pkg::ZONE_W'(1));
						res_status_q <= pwz_pkg::STAT_OK;
						res_zmode_q <= pwz_pkg::MODE_COMFORT;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (act_q)
						pwz_pkg::ACT_SET: begin
							state_q <= S_FINISH;
							if (!zone_ok_q || mode_q > pwz_pkg::MODE_C2) begin
								res_status_q <= pwz_pkg::STAT_INVALID;
							end else begin
								saved_mode_q[idx_q] <= mode_q;
								if (cur_mode == pwz_pkg::MODE_SHED) begin
									res_status_q <= pwz_pkg::STAT_STORED;
								end else begin
									zone_state_q[idx_q] <= mode_q;
									if (mode_q == pwz_pkg::MODE_C1 || mode_q == pwz_pkg::MODE_C2) begin
										phase_q[idx_q].count <= pwz_pkg::CFG_W'(1);
										phase_q[idx_q].low <= 1'b0;
									end
								end
							end
						end
						pwz_pkg::ACT_QUERY: begin
							state_q <= S_FINISH;
							if (!zone_ok_q)
								res_status_q <= pwz_pkg::STAT_INVALID;
							else
								res_zmode_q <= cur_mode;
						end
						pwz_pkg::ACT_SHED: begin
							state_q <= (shed_cnt_q < CW'(ZONES)) ? S_SHPREP : S_FINISH;
						end
						pwz_pkg::ACT_RESTORE: begin
							if (shed_cnt_q != '0) begin
								idx_q <= rest_idx;
								state_q <= S_REST;
							end else begin
								state_q <= S_FINISH;
							end
						end
						pwz_pkg::ACT_ROTATE: begin
							if (shed_cnt_q != '0 && shed_cnt_q < CW'(ZONES)) begin
								idx_q <= rest_idx;
								state_q <= S_REST;
							end else begin
								state_q <= S_FINISH;
							end
						end
						pwz_pkg::ACT_TICK: begin
							idx_q <= '0;
							state_q <= S_TICK;
						end
						default: begin
							res_status_q <= pwz_pkg::STAT_INVALID;
							state_q <= S_FINISH;
						end
					endcase
				end
				S_REST: begin
					zone_state_q[idx_q] <= cur_saved;
					if (cur_saved == pwz_pkg::MODE_C1 || cur_saved == pwz_pkg::MODE_C2) begin
						phase_q[idx_q].count <= pwz_pkg::CFG_W'(1);
						phase_q[idx_q].low <= 1'b0;
					end
					shed_cnt_q <= shed_cnt_q - CW'(1);
					oldest_q <= oldest_next;
					state_q <= (act_q == pwz_pkg::ACT_ROTATE) ? S_SHPREP : S_FINISH;
				end
				S_SHPREP: begin
					idx_q <= shed_idx;
					state_q <= S_SHED;
				end
				S_SHED: begin
					zone_state_q[idx_q] <= pwz_pkg::MODE_SHED;
					shed_cnt_q <= shed_cnt_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_TICK: begin
					phase_q[idx_q] <= phase_nxt;
					if (idx_q == IW'(ZONES - 1))
						state_q <= S_FINISH;
					else
						idx_q <= idx_q + IW'(1);
				end
				S_FINISH: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			status_q <= res_status_q;
			zone_mode_q <= res_zmode_q;
			drive_q <= drv_pad[pwz_pkg::DRIVE_W-1:0];
			shed_level_q <= pwz_pkg::LEVEL_W'(shed_cnt_q);
			oldest_out_q <= pwz_pkg::PTR_W'(oldest_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign zone_mode = zone_mode_q;
	assign drive = drive_q;
	assign shed_level = shed_level_q;
	assign oldest_shed_zone = oldest_out_q;

endmodule

// File: rtl/pwz_phase_unit.sv
// ----------------------------------------------------------------------------
// pwz_phase_unit: comfort-1 / comfort-2 duty cycle step
// one compare and increment, shared over the zones by the tick sweep
// ----------------------------------------------------------------------------
module pwz_phase_unit (
	input  logic [pwz_pkg::MODE_W-1:0] mode,
	input  pwz_pkg::phase_t            cur,
	input  pwz_pkg::cfg_t              cfg,
	output pwz_pkg::phase_t            nxt
);

	logic [pwz_pkg::CFG_W-1:0] on_t;
	logic [pwz_pkg::CFG_W-1:0] off_t;
	logic [pwz_pkg::CFG_W-1:0] limit;
	logic                      duty;

	always_comb begin
		duty = 1'b1;
		on_t = cfg.c1_on;
		off_t = cfg.c1_off;
		case (mode)
			pwz_pkg::MODE_C1: begin
				on_t = cfg.c1_on;
				off_t = cfg.c1_off;
			end
			pwz_pkg::MODE_C2: begin
				on_t = cfg.c2_on;
				off_t = cfg.c2_off;
			end
			default: duty = 1'b0;
		endcase
		limit = cur.low ? off_t : on_t;

		if (!duty) begin
			nxt.count = '0;
			nxt.low = 1'b0;
		end else if (cur.count >= limit) begin
			nxt.count = pwz_pkg::CFG_W'(1);
			nxt.low = ~cur.low;
		end else begin
			nxt.count = cur.count + pwz_pkg::CFG_W'(1);
			nxt.low = cur.low;
		end
	end

endmodule

// File: rtl/pwz_checker.sv
// ----------------------------------------------------------------------------
// pwz_checker: port-level checks for the zone controller
// bound to the top level
// ----------------------------------------------------------------------------
module pwz_checker #(
	parameter int ZONES = pwz_pkg::ZONES_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [pwz_pkg::STATUS_W-1:0] status,
	input logic [pwz_pkg::MODE_W-1:0]   zone_mode,
	input logic [pwz_pkg::LEVEL_W-1:0]  shed_level,
	input logic [pwz_pkg::PTR_W-1:0]    oldest_shed_zone
);

	// one request at a time: busy right after a request is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while a previous one was not finished");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= pwz_pkg::STAT_STORED)
		else $error("undefined status code");

	a_reject_no_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pwz_pkg::STAT_OK |-> zone_mode == pwz_pkg::MODE_COMFORT)
		else $error("zone mode reported with a failed or stored-only request");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ZONES < 8 |-> shed_level <= pwz_pkg::LEVEL_W'(ZONES) &&
			oldest_shed_zone != '0 && oldest_shed_zone <= pwz_pkg::PTR_W'(ZONES))
		else $error("shed level or oldest pointer out of range");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(shed_level))
		else $error("stalled result changed");

endmodule

bind pilot_wire_zone_controller_with_shedding_core pwz_checker #(.ZONES(ZONES)) u_pwz_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.status           (status),
	.zone_mode        (zone_mode),
	.shed_level       (shed_level),
	.oldest_shed_zone (oldest_shed_zone)
);

// File: tb/pwz_result_checker.sv
// ----------------------------------------------------------------------------
// pwz_result_checker
// keeps its own copy of the zone, shedding and duty-cycle state, predicts
// the result of every accepted request and compares each delivered result
// with the oldest prediction, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwz_result_checker #(
	parameter int ZONES = pwz_pkg::ZONES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pwz_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwz_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [pwz_pkg::ACTION_W-1:0]    action,
	input  logic [pwz_pkg::ZONE_W-1:0]      zone,
	input  logic [pwz_pkg::MODE_W-1:0]      mode,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [pwz_pkg::STATUS_W-1:0]    status,
	input  logic [pwz_pkg::MODE_W-1:0]      zone_mode,
	input  logic [pwz_pkg::DRIVE_W-1:0]     drive,
	input  logic [pwz_pkg::LEVEL_W-1:0]     shed_level,
	input  logic [pwz_pkg::PTR_W-1:0]       oldest_shed_zone,
	output int                              outstanding,
	output int                              mismatches,
	output int                              checked
);
	import pwz_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MODE_W-1:0] zmode;
		logic [DRIVE_W-1:0] drive;
		logic [LEVEL_W-1:0] level;
		logic [PTR_W-1:0] oldest;
	} zone_result_t;

	logic [MODE_W-1:0] zstate [ZONES];
	logic [MODE_W-1:0] saved [ZONES];
	logic [CFG_W-1:0] pcount [ZONES];
	logic low_ph [ZONES];
	int shed_n;
	int oldest_z;
	cfg_t timing;
	zone_result_t predicted_q[$];
	int n_issued;
	int n_seen;
	int n_bad;

	function automatic void enter_mode(int zi, logic [MODE_W-1:0] m);
		zstate[zi] = m;
		// duty-cycle modes always restart in the high phase
		if (m == MODE_C1 || m == MODE_C2) begin
			pcount[zi] = 1;
			low_ph[zi] = 1'b0;
		end
	endfunction

	function automatic void shed_next_zone();
		if (shed_n < ZONES) begin
			shed_n++;
			enter_mode((oldest_z - 1 + shed_n - 1) % ZONES, MODE_SHED);
		end
	endfunction

	function automatic void restore_oldest_zone();
		int zi;
		if (shed_n > 0) begin
			zi = (oldest_z - 1) % ZONES;
			shed_n--;
			enter_mode(zi, saved[zi]);
			oldest_z = (oldest_z % ZONES) + 1;
		end
	endfunction

	function automatic void step_duty_cycles();
		logic [CFG_W-1:0] limit;
		for (int i = 0; i < ZONES; i++) begin
			if (zstate[i] == MODE_C1 || zstate[i] == MODE_C2) begin
				if (zstate[i] == MODE_C1)
					limit = low_ph[i] ? timing.c1_off : timing.c1_on;
				else
					limit = low_ph[i] ? timing.c2_off : timing.c2_on;
				if (pcount[i] >= limit) begin
					low_ph[i] = !low_ph[i];
					pcount[i] = 1;
				end else begin
					pcount[i] = pcount[i] + 1'b1;
				end
			end else begin
				pcount[i] = '0;
				low_ph[i] = 1'b0;
			end
		end
	endfunction

	function automatic logic [DRIVE_W-1:0] drive_word();
		logic [DRIVE_W-1:0] w;
		logic [1:0] pat;
		w = '0;
		for (int i = 0; i < ZONES && 2 * i < DRIVE_W; i++) begin
			case (zstate[i])
				MODE_COMFORT: pat = DRV_COMFORT;
				MODE_ECO: pat = DRV_ECO;
				MODE_OFF: pat = DRV_OFF;
				MODE_C1, MODE_C2: pat = low_ph[i] ? DRV_COMFORT : DRV_ECO;
				default: pat = DRV_FROST;
			endcase
			w[2 * i +: 2] = pat;
		end
		return w;
	endfunction

	function automatic zone_result_t serve_request(logic [ACTION_W-1:0] a,
			logic [ZONE_W-1:0] z, logic [MODE_W-1:0] m);
		zone_result_t r;
		logic zone_ok;
		int zi;
		r = '0;
		zone_ok = (z >= 1) && (z <= ZONES);
		zi = int'(z) - 1;
		case (a)
			ACT_SET: begin
				if (!zone_ok || m > MODE_C2) begin
					r.status = STAT_INVALID;
				end else begin
					saved[zi] = m;
					if (zstate[zi] == MODE_SHED)
						r.status = STAT_STORED;
					else
						enter_mode(zi, m);
				end
			end
			ACT_QUERY: begin
				if (!zone_ok)
					r.status = STAT_INVALID;
				else
					r.zmode = zstate[zi];
			end
			ACT_SHED: shed_next_zone();
			ACT_RESTORE: restore_oldest_zone();
			ACT_ROTATE: begin
				// no-op when nothing or everything is shed
				if (shed_n > 0 && shed_n < ZONES) begin
					restore_oldest_zone();
					shed_next_zone();
				end
			end
			ACT_TICK: step_duty_cycles();
			default: r.status = STAT_INVALID;
		endcase
		r.drive = drive_word();
		r.level = shed_n[LEVEL_W-1:0];
		r.oldest = oldest_z[PTR_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		zone_result_t want;
		zone_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < ZONES; i++) begin
				zstate[i] = MODE_FROST;
				saved[i] = MODE_FROST;
				pcount[i] = '0;
				low_ph[i] = 1'b0;
			end
			shed_n = 0;
			oldest_z = 1;
			timing = '{c1_on: C1_ON_RST, c1_off: C1_OFF_RST, c2_on: C2_ON_RST,
				c2_off: C2_OFF_RST};
			predicted_q.delete();
			n_issued = 0;
			n_seen = 0;
			n_bad = 0;
		end else begin
			if (cfg_wr_en === 1'b1) begin
				case (cfg_index)
					REG_C1_ON: timing.c1_on = cfg_data;
					REG_C1_OFF: timing.c1_off = cfg_data;
					REG_C2_ON: timing.c2_on = cfg_data;
					REG_C2_OFF: timing.c2_off = cfg_data;
					default: ;
				endcase
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				predicted_q.push_back(serve_request(action, zone, mode));
				n_issued++;
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got = '{status: status, zmode: zone_mode, drive: drive, level: shed_level,
					oldest: oldest_shed_zone};
				n_seen++;
				if (predicted_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: result with no request pending: status %0d drive %h",
							$realtime, got.status, got.drive);
				end else begin
					want = predicted_q.pop_front();
					if (got.status !== want.status || got.zmode !== want.zmode ||
							got.drive !== want.drive || got.level !== want.level ||
							got.oldest !== want.oldest) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"%0t: result %0d mismatch: expected status %0d ",
								"zone_mode %0d drive %h level %0d oldest %0d, got status %0d ",
								"zone_mode %0d drive %h level %0d oldest %0d"},
								$realtime, n_seen, want.status, want.zmode, want.drive,
								want.level, want.oldest, got.status, got.zmode, got.drive,
								got.level, got.oldest);
					end
				end
			end
		end
		outstanding <= n_issued - n_seen;
		mismatches <= n_bad;
		checked <= n_seen;
	end

endmodule

// File: tb/pilot_wire_zone_controller_with_shedding_core_test.sv
// ----------------------------------------------------------------------------
// pilot_wire_zone_controller_with_shedding_core_test
// drives directed and random zone, shedding and tick requests through the
// controller under random gaps and output stalls, over several phase-length
// settings, and reports the verdict from the result checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pilot_wire_zone_controller_with_shedding_core_test;
	import pwz_pkg::*;

	localparam int ZONES = ZONES_DEF;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int PHASES = 7;
	localparam int CYCLE_LIMIT = 250000;

	// action and mode codes that the block must reject
	localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
	localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ACTION_W-1:0] action = '0;
	logic [ZONE_W-1:0] zone = '0;
	logic [MODE_W-1:0] mode = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [MODE_W-1:0] zone_mode;
	logic [DRIVE_W-1:0] drive;
	logic [LEVEL_W-1:0] shed_level;
	logic [PTR_W-1:0] oldest_shed_zone;

	int outstanding;
	int mismatches;
	int checked;
	bit steady = 1'b0;
	int n_sent = 0;
	int n_ticks = 0;
	int n_shedding = 0;
	int n_settings = 1;
	int cycle_cnt = 0;

	pilot_wire_zone_controller_with_shedding_core #(.ZONES(ZONES)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .zone(zone), .mode(mode),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .zone_mode(zone_mode), .drive(drive),
		.shed_level(shed_level), .oldest_shed_zone(oldest_shed_zone)
	);

	pwz_result_checker #(.ZONES(ZONES)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .zone(zone), .mode(mode),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .zone_mode(zone_mode), .drive(drive),
		.shed_level(shed_level), .oldest_shed_zone(oldest_shed_zone),
		.outstanding(outstanding), .mismatches(mismatches), .checked(checked)
	);

	initial forever #6 clk = ~clk;

	function automatic int pick_wait();
		return steady ? 0 : $urandom_range(0, 14);
	endfunction

	// one request: optional gap, then hold it until the block takes it
	task automatic issue(logic [ACTION_W-1:0] a, logic [ZONE_W-1:0] z,
			logic [MODE_W-1:0] m);
		int w;
		w = pick_wait();
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		zone <= z;
		mode <= m;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
		if (a == ACT_TICK)
			n_ticks++;
		if (a == ACT_SHED || a == ACT_RESTORE || a == ACT_ROTATE)
			n_shedding++;
	endtask

	// hold off until every pending result has been delivered
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (ZONES + 4) @(posedge clk);
	endtask

	task automatic load_timing(logic [CFG_W-1:0] c1_on, logic [CFG_W-1:0] c1_off,
			logic [CFG_W-1:0] c2_on, logic [CFG_W-1:0] c2_off);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_C1_ON;
		cfg_data <= c1_on;
		@(posedge clk);
		cfg_index <= REG_C1_OFF;
		cfg_data <= c1_off;
		@(posedge clk);
		cfg_index <= REG_C2_ON;
		cfg_data <= c2_on;
		@(posedge clk);
		cfg_index <= REG_C2_OFF;
		cfg_data <= c2_off;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	task automatic random_request(bit shed_heavy);
		int r;
		int pick;
		logic [ZONE_W-1:0] any_zone;
		logic [MODE_W-1:0] any_mode;
		logic [ZONE_W-1:0] good_zone;
		r = $urandom_range(0, 99);
		any_zone = ZONE_W'($urandom_range(0, 15));
		any_mode = MODE_W'($urandom_range(0, 7));
		good_zone = ZONE_W'($urandom_range(1, ZONES));
		if (r < 5) begin
			pick = $urandom_range(0, 2);
			if (pick == 0)
				issue($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO, any_zone, any_mode);
			else if (pick == 1)
				issue($urandom_range(0, 1) ? ACT_SET : ACT_QUERY,
					($urandom_range(0, 3) == 0) ? ZONE_W'(0) :
					ZONE_W'($urandom_range(ZONES + 1, 15)), any_mode);
			else
				issue(ACT_SET, good_zone, $urandom_range(0, 1) ? MODE_SPARE : MODE_SHED);
		end else if (r < 35) begin
			// lean on the duty-cycle modes so ticks have something to step
			if ($urandom_range(0, 9) < 5)
				issue(ACT_SET, good_zone, $urandom_range(0, 1) ? MODE_C2 : MODE_C1);
			else
				issue(ACT_SET, good_zone, MODE_W'($urandom_range(0, 5)));
		end else if (r < 48) begin
			issue(ACT_QUERY, good_zone, any_mode);
		end else if (r < 73) begin
			issue(ACT_TICK, any_zone, any_mode);
		end else begin
			pick = $urandom_range(0, 9);
			if (pick < (shed_heavy ? 6 : 4))
				issue(ACT_SHED, any_zone, any_mode);
			else if (pick < (shed_heavy ? 8 : 7))
				issue(ACT_RESTORE, any_zone, any_mode);
			else
				issue(ACT_ROTATE, any_zone, any_mode);
		end
	endtask

	// result side: random stall before each result, none during steady stretches
	initial begin : result_sink
		int hold;
		forever begin
			hold = pick_wait();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results still pending", cycle_cnt, outstanding);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every action, bad zones and modes, shedding at both ends
		issue(ACT_SET, 4'd1, MODE_COMFORT);
		issue(ACT_SET, 4'd4, MODE_C1);
		issue(ACT_SET, 4'd5, MODE_C2);
		issue(ACT_SET, 4'd0, MODE_ECO);
		issue(ACT_SET, 4'd15, MODE_COMFORT);
		issue(ACT_SET, 4'd6, MODE_SHED);
		issue(ACT_SET, 4'd6, MODE_SPARE);
		issue(ACT_QUERY, 4'd0, MODE_COMFORT);
		issue(ACT_QUERY, 4'd4, MODE_COMFORT);
		issue(ACT_SPARE_LO, 4'd0, MODE_COMFORT);
		issue(ACT_SPARE_HI, 4'd15, MODE_SPARE);
		issue(ACT_RESTORE, 4'd0, MODE_COMFORT);
		issue(ACT_ROTATE, 4'd0, MODE_COMFORT);
		issue(ACT_TICK, 4'd0, MODE_COMFORT);
		issue(ACT_SHED, 4'd0, MODE_COMFORT);
		// zone 1 is shed now: the set is only stored
		issue(ACT_SET, 4'd1, MODE_OFF);
		issue(ACT_QUERY, 4'd1, MODE_COMFORT);
		issue(ACT_ROTATE, 4'd0, MODE_COMFORT);
		// fill the ring, then one more shed at full level
		repeat (ZONES) issue(ACT_SHED, 4'd0, MODE_COMFORT);
		issue(ACT_ROTATE, 4'd0, MODE_COMFORT);
		issue(ACT_RESTORE, 4'd0, MODE_COMFORT);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				quiesce();
				case (ph)
					1: load_timing(9'd1, 9'd1, 9'd1, 9'd1);
					2: load_timing(9'd511, 9'd511, 9'd511, 9'd511);
					3: load_timing(9'd2, 9'd5, 9'd3, 9'd4);
					4: load_timing(9'd1, 9'd511, 9'd511, 9'd1);
					5: load_timing(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)),
						CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)));
					default: load_timing(CFG_W'($urandom_range(1, 511)),
						CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
						CFG_W'($urandom_range(1, 511)));
				endcase
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				steady = (ph == 3) || (k % 32 < 6);
				random_request(ph % 2 == 1);
			end
		end

		steady = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4 * (ZONES + 2)) @(posedge clk);

		$display("%0d requests sent (%0d ticks, %0d shed/restore/rotate) over %0d timing settings",
			n_sent, n_ticks, n_shedding, n_settings);
		$display("%0d results compared, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
